// ----- rtl/sfs_pkg.sv -----
package sfs_pkg;

	// default sizing
	localparam int DEF_MAX_FRAMES = 256;
	localparam int DEF_TIME_BITS  = 16;

	// configuration register map
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COUNT  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_PERIOD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLAY_MODE    = 2'd2;

	// register widths and reset values
	localparam int FCNT_BITS = 9;
	localparam int FPER_BITS = 16;
	localparam int MODE_BITS = 3;
	localparam logic [FCNT_BITS-1:0] FCNT_RESET = 9'd1;
	localparam logic [FPER_BITS-1:0] FPER_RESET = 16'd1000;
	localparam logic [MODE_BITS-1:0] MODE_RESET = 3'd4;

	// play_mode bit0: start at the last frame going backward
	localparam int MODE_REV_START = 0;

	// item fields
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_PLAY = 1'b1;
	localparam int ELAPSED_BITS = 16;
	localparam int FRAME_IDX_BITS = 8;
	localparam int OUT_DATA_BITS = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FMOD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ACT_WRAP,
		ACT_STOP,
		ACT_REVERSE
	} end_act_t;

endpackage

// ----- rtl/sprite_frame_sequencer.sv -----
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  tuser: opcode; tdata: elapsed
// m_*       out  m_tvalid / m_tready  tdata: frame_index, is_running, going_back
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Steps: a play or a stopped tick goes to DONE; a running tick goes to RUN, where each frame
// step subtracts the period, then checks the count in FMOD, looping after a mid-play count
// drop; a wrap up from frame 0 or a stop skips FMOD; stopped, RUN still takes off periods.
// Reset: asynchronous, active low; registers to defaults, stopped at frame 0, forward,
// first-tick flag armed. No clearing pass.
// Stalls: the next item is taken while a result waits in the output register; a finished
// item then waits in DONE until that register is free.
module sprite_frame_sequencer #(
	parameter int MAX_FRAMES = sfs_pkg::DEF_MAX_FRAMES,
	parameter int TIME_BITS  = sfs_pkg::DEF_TIME_BITS
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [sfs_pkg::ELAPSED_BITS-1:0]      s_tdata,   // [15:0] elapsed
	input  logic                                  s_tuser,   // [0] opcode

	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [sfs_pkg::OUT_DATA_BITS-1:0]     m_tdata,   // [7:0] frame_index,
	                                                         // [8] is_running,
	                                                         // [9] going_back, rest 0

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sfs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [sfs_pkg::FPER_BITS-1:0]         cfg_data
);

	// frame numbers run 0..MAX_FRAMES-1; FW+1 bits hold the count and one step past it
	localparam int FW  = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
	localparam int ATW = TIME_BITS + 1;                 // accumulator width
	localparam int W   = (ATW > FW + 1) ? ATW : FW + 1; // shared unit width

	// configuration registers
	logic [sfs_pkg::FCNT_BITS-1:0] fcnt_q;
	logic [sfs_pkg::FPER_BITS-1:0] fper_q;
	logic [sfs_pkg::MODE_BITS-1:0] mode_q;

	// playback state
	sfs_pkg::state_t state_q, state_d;
	logic [ATW-1:0] acc_q, acc_d;
	logic           first_q, first_d;
	logic           running_q, running_d;
	logic           back_q, back_d;
	logic [FW-1:0]  cf_q, cf_d;
	logic [FW:0]    r_q, r_d;       // frame candidate under modulo fix-up

	// output register
	logic                              m_valid_q;
	logic [sfs_pkg::OUT_DATA_BITS-1:0] m_data_q;
	logic                              out_load;
	logic                              out_free;

	// effective count and period
	logic [31:0]          fcnt_w, fc_w, per_w, el_w;
	logic [FW:0]          fc, fc_m1;
	logic [TIME_BITS-1:0] p_raw, p, el_t;
	logic [ATW-1:0]       acc_sum;

	// shared compare/subtract unit
	logic [W-1:0] ua, ub;
	logic [W:0]   udiff;
	logic         uge;

	// end handling
	logic           hit_top, hit_bot;
	logic           run_s, back_s;
	sfs_pkg::end_act_t act;
	logic [FW:0]    cf_up, cf_dn;

	function automatic sfs_pkg::end_act_t end_action(
		input logic [sfs_pkg::MODE_BITS-1:0] m,
		input logic                          top
	);
		sfs_pkg::end_act_t a;
		a = sfs_pkg::ACT_WRAP;
		if (top) begin
			if (m inside {3'd0, 3'd3}) a = sfs_pkg::ACT_STOP;
			else if (m inside {3'd2, 3'd6, 3'd7}) a = sfs_pkg::ACT_REVERSE;
		end else begin
			if (m inside {3'd1, 3'd2}) a = sfs_pkg::ACT_STOP;
			else if (m inside {3'd3, 3'd6, 3'd7}) a = sfs_pkg::ACT_REVERSE;
		end
		return a;
	endfunction

	assign s_tready  = (state_q == sfs_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_free  = !m_valid_q || m_tready;

	// zero count reads as 1, counts above MAX_FRAMES clamp
	always_comb begin
		fcnt_w = 32'(fcnt_q);
		if (fcnt_q == '0) fc_w = 32'd1;
		else if (fcnt_w > 32'(MAX_FRAMES)) fc_w = 32'(MAX_FRAMES);
		else fc_w = fcnt_w;
	end
	assign fc    = fc_w[FW:0];
	assign fc_m1 = fc - (FW+1)'(1);

	// period masked to TIME_BITS, zero reads as 1
	assign per_w = 32'(fper_q);
	assign p_raw = per_w[TIME_BITS-1:0];
	assign p     = (p_raw == '0) ? TIME_BITS'(1) : p_raw;
	assign el_w  = 32'(s_tdata);
	assign el_t  = el_w[TIME_BITS-1:0];
	assign acc_sum = acc_q + ATW'(el_t);

	// unit: accumulator minus period in RUN, candidate minus count in FMOD
	assign ua    = (state_q == sfs_pkg::ST_FMOD) ? W'(r_q) : W'(acc_q);
	assign ub    = (state_q == sfs_pkg::ST_FMOD) ? W'(fc)  : W'(p);
	assign udiff = {1'b0, ua} - {1'b0, ub};
	assign uge   = ~udiff[W];

	assign cf_up   = {1'b0, cf_q} + (FW+1)'(1);
	assign cf_dn   = {1'b0, cf_q} - (FW+1)'(1);
	assign hit_bot = back_q && (cf_q == '0);
	assign hit_top = back_q ? ((cf_q != '0) && (cf_dn == fc)) : (cf_up == fc);

	always_comb begin
		act    = end_action(mode_q, hit_top);
		run_s  = 1'b1;
		back_s = back_q;
		if (hit_top || hit_bot) begin
			case (act)
				sfs_pkg::ACT_STOP:    run_s  = 1'b0;
				sfs_pkg::ACT_REVERSE: back_s = !back_q;
				default:              back_s = back_q;
			endcase
		end
	end

	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		first_d   = first_q;
		running_d = running_q;
		back_d    = back_q;
		cf_d      = cf_q;
		r_d       = r_q;
		out_load  = 1'b0;
		case (state_q)
			sfs_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == sfs_pkg::OP_PLAY) begin
						running_d = 1'b1;
						first_d   = 1'b1;
						acc_d     = '0;
						if (mode_q[sfs_pkg::MODE_REV_START]) begin
							back_d = 1'b1;
							cf_d   = fc_m1[FW-1:0];
						end else begin
							back_d = 1'b0;
							cf_d   = '0;
						end
						state_d = sfs_pkg::ST_DONE;
					end else if (running_q) begin
						if (first_q) begin
							acc_d   = '0;
							first_d = 1'b0;
						end else begin
							acc_d = acc_sum;
						end
						state_d = sfs_pkg::ST_RUN;
					end else begin
						// tick while stopped changes nothing
						state_d = sfs_pkg::ST_DONE;
					end
				end
			end
			sfs_pkg::ST_RUN: begin
				if (uge) begin
					// once stopped, the loop carries on as the modulo by the period
					acc_d = udiff[ATW-1:0];
					if (running_q) begin
						if (run_s) begin
							back_d = back_s;
							if (back_s) begin
								if (cf_q == '0) begin
									cf_d = fc_m1[FW-1:0];
								end else begin
									r_d     = cf_dn;
									state_d = sfs_pkg::ST_FMOD;
								end
							end else begin
								r_d     = cf_up;
								state_d = sfs_pkg::ST_FMOD;
							end
						end else begin
							running_d = 1'b0;
						end
					end
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = sfs_pkg::ST_IDLE;
				end else begin
					state_d = sfs_pkg::ST_DONE;
				end
			end
			sfs_pkg::ST_FMOD: begin
				if (uge) begin
					r_d = udiff[FW:0];
				end else begin
					cf_d    = r_q[FW-1:0];
					state_d = sfs_pkg::ST_RUN;
				end
			end
			sfs_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = sfs_pkg::ST_IDLE;
				end
			end
			default: state_d = sfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sfs_pkg::ST_IDLE;
			acc_q     <= '0;
			first_q   <= 1'b1;
			running_q <= 1'b0;
			back_q    <= 1'b0;
			cf_q      <= '0;
		end else begin
			state_q   <= state_d;
			acc_q     <= acc_d;
			first_q   <= first_d;
			running_q <= running_d;
			back_q    <= back_d;
			cf_q      <= cf_d;
		end
	end

	always_ff @(posedge clk) begin
		r_q <= r_d;
	end

	// configuration writes; an index past the map is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= sfs_pkg::FCNT_RESET;
			fper_q <= sfs_pkg::FPER_RESET;
			mode_q <= sfs_pkg::MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfs_pkg::REG_FRAME_COUNT:  fcnt_q <= cfg_data[sfs_pkg::FCNT_BITS-1:0];
				sfs_pkg::REG_FRAME_PERIOD: fper_q <= cfg_data;
				sfs_pkg::REG_PLAY_MODE:    mode_q <= cfg_data[sfs_pkg::MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {6'b0, back_q, running_q, sfs_pkg::FRAME_IDX_BITS'(cf_q)};
		end
	end

`ifndef SYNTH
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again straight after a transfer");

	a_fixup_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfs_pkg::ST_FMOD && !uge) |=> ({1'b0, cf_q} < fc))
		else $error("frame left at or above count after fix-up");

	a_stopped_frame_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfs_pkg::ST_RUN && !running_q) |=> $stable(cf_q))
		else $error("frame moved while stopped");

	a_accum_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfs_pkg::ST_RUN && !uge) |=> (W'(acc_q) < W'(p)))
		else $error("accumulator not below period at end of tick");
`endif

endmodule

// ----- tb/sfs_checker.sv -----
`timescale 1ns / 1ps

module sfs_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [sfs_pkg::ELAPSED_BITS-1:0]     s_tdata,   // [15:0] elapsed
	input  logic                                 s_tuser,   // [0] opcode
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [sfs_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // [7:0] frame_index,
	                                                        // [8] is_running,
	                                                        // [9] going_back, rest 0
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [sfs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [sfs_pkg::FPER_BITS-1:0]        cfg_data,
	output int                                   mismatches,
	output int                                   results_due
);

	typedef struct packed {
		logic [sfs_pkg::FRAME_IDX_BITS-1:0] frame;
		logic                               run;
		logic                               back;
	} frame_view_t;

	// shadow registers
	logic [sfs_pkg::FCNT_BITS-1:0] count_reg;
	logic [sfs_pkg::FPER_BITS-1:0] period_reg;
	logic [sfs_pkg::MODE_BITS-1:0] mode_reg;

	// shadow playback state
	logic [sfs_pkg::DEF_TIME_BITS:0]      accum;
	logic                                 first_pend;
	logic                                 playing;
	logic                                 reverse;
	logic [sfs_pkg::FRAME_IDX_BITS-1:0]   frame;

	frame_view_t expected_frames[$];
	int          errs;

	function automatic int frames_in_use(logic [sfs_pkg::FCNT_BITS-1:0] c);
		if (c == '0)
			return 1;
		if (c > sfs_pkg::DEF_MAX_FRAMES)
			return sfs_pkg::DEF_MAX_FRAMES;
		return int'(c);
	endfunction

	function automatic sfs_pkg::end_act_t top_end_act(logic [sfs_pkg::MODE_BITS-1:0] m);
		case (m)
			3'd0, 3'd3:       return sfs_pkg::ACT_STOP;
			3'd2, 3'd6, 3'd7: return sfs_pkg::ACT_REVERSE;
			default:          return sfs_pkg::ACT_WRAP;
		endcase
	endfunction

	function automatic sfs_pkg::end_act_t bottom_end_act(logic [sfs_pkg::MODE_BITS-1:0] m);
		case (m)
			3'd1, 3'd2:       return sfs_pkg::ACT_STOP;
			3'd3, 3'd6, 3'd7: return sfs_pkg::ACT_REVERSE;
			default:          return sfs_pkg::ACT_WRAP;
		endcase
	endfunction

	task automatic advance_one_frame();
		int                fc;
		int                nxt;
		sfs_pkg::end_act_t act;
		fc  = frames_in_use(count_reg);
		nxt = int'(frame) + (reverse ? -1 : 1);
		if (nxt == fc)
			act = top_end_act(mode_reg);
		else if (nxt < 0)
			act = bottom_end_act(mode_reg);
		else
			act = sfs_pkg::ACT_WRAP;
		if (act == sfs_pkg::ACT_STOP)
			playing = 1'b0;
		else if (act == sfs_pkg::ACT_REVERSE)
			reverse = !reverse;
		if (playing) begin
			nxt = int'(frame) + (reverse ? -1 : 1);
			if (nxt < 0)
				frame = sfs_pkg::FRAME_IDX_BITS'(fc - 1);
			else
				frame = sfs_pkg::FRAME_IDX_BITS'(nxt % fc);   // also folds a lowered count
		end
	endtask

	task automatic advance_playback(logic op, logic [sfs_pkg::ELAPSED_BITS-1:0] el);
		logic [sfs_pkg::DEF_TIME_BITS:0] per;
		frame_view_t                     view;
		per = (period_reg == '0) ? 17'd1 : {1'b0, period_reg};
		if (op == sfs_pkg::OP_PLAY) begin
			playing    = 1'b1;
			first_pend = 1'b1;
			accum      = '0;
			if (mode_reg[sfs_pkg::MODE_REV_START]) begin
				reverse = 1'b1;
				frame   = sfs_pkg::FRAME_IDX_BITS'(frames_in_use(count_reg) - 1);
			end else begin
				reverse = 1'b0;
				frame   = '0;
			end
		end else if (playing) begin
			if (first_pend) begin
				accum      = '0;
				first_pend = 1'b0;
			end else begin
				accum = accum + (sfs_pkg::DEF_TIME_BITS+1)'(el);
			end
			while (playing && accum >= per) begin
				accum = accum - per;
				advance_one_frame();
			end
			if (!playing)
				accum = accum % per;
		end
		view = '{frame, playing, reverse};
		expected_frames.insert(expected_frames.size(), view);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_view_t want;
		if (!arst_n) begin
			count_reg  = sfs_pkg::FCNT_RESET;
			period_reg = sfs_pkg::FPER_RESET;
			mode_reg   = sfs_pkg::MODE_RESET;
			accum      = '0;
			first_pend = 1'b1;
			playing    = 1'b0;
			reverse    = 1'b0;
			frame      = '0;
			expected_frames.delete();
			errs       = 0;
		end else begin
			// results first: a result leaving on this edge belongs to an older item
			if (m_tvalid && m_tready) begin
				if (expected_frames.size() == 0) begin
					$error("unexpected result transfer, tdata %h", m_tdata);
					errs++;
				end else begin
					want = expected_frames.pop_front();
					if (m_tdata[7:0] !== want.frame) begin
						$error("frame_index: expected %0d, actual %0d", want.frame, m_tdata[7:0]);
						errs++;
					end
					if (m_tdata[8] !== want.run) begin
						$error("is_running: expected %0b, actual %0b", want.run, m_tdata[8]);
						errs++;
					end
					if (m_tdata[9] !== want.back) begin
						$error("going_back: expected %0b, actual %0b", want.back, m_tdata[9]);
						errs++;
					end
					if (m_tdata[sfs_pkg::OUT_DATA_BITS-1:10] !== '0) begin
						$error("tdata padding: expected 0, actual %h",
							m_tdata[sfs_pkg::OUT_DATA_BITS-1:10]);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sfs_pkg::REG_FRAME_COUNT:
						count_reg  = cfg_data[sfs_pkg::FCNT_BITS-1:0];
					sfs_pkg::REG_FRAME_PERIOD:
						period_reg = cfg_data;
					sfs_pkg::REG_PLAY_MODE:
						mode_reg   = cfg_data[sfs_pkg::MODE_BITS-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				advance_playback(s_tuser, s_tdata);
		end
		mismatches  <= errs;
		results_due <= expected_frames.size();
	end

endmodule

// ----- tb/sprite_frame_sequencer_tb.sv -----
`timescale 1ns / 1ps

module sprite_frame_sequencer_tb;

	// index with no register behind it; writes must be ignored
	localparam logic [sfs_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	localparam int RX_HOLD_CYCLES  = 200;  // long receiver hold-off, fills the block up
	localparam int RAND_PHASES     = 20;
	localparam int ITEMS_PER_PHASE = 45;
	localparam int CALM_PHASES     = 3;    // closing phases run with no idling at all
	localparam int HOLD_PHASE      = 2;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [sfs_pkg::ELAPSED_BITS-1:0] s_tdata   = '0;
	logic                             s_tuser   = sfs_pkg::OP_TICK;

	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [sfs_pkg::OUT_DATA_BITS-1:0] m_tdata;

	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [sfs_pkg::CFG_IDX_BITS-1:0] cfg_index = sfs_pkg::REG_FRAME_COUNT;
	logic [sfs_pkg::FPER_BITS-1:0]    cfg_data  = '0;

	int chk_errors;
	int results_due;

	// stimulus shaping
	logic                          idle_on     = 1'b1;
	logic                          rx_hold_req = 1'b0;
	int                            rx_gap      = 0;
	logic [sfs_pkg::FPER_BITS-1:0] period_now  = sfs_pkg::FPER_RESET;  // keeps times sensible

	always #5 clk = ~clk;

	sprite_frame_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sfs_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (chk_errors),
		.results_due (results_due)
	);

	// All stimulus tasks start by moving to a falling edge; send_item returns on the rising
	// edge that completed its transfer, write_reg once it has dropped cfg_valid again.

	// One register write. Only called once the block has gone quiet.
	task automatic write_reg(logic [sfs_pkg::CFG_IDX_BITS-1:0] idx,
		logic [sfs_pkg::FPER_BITS-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == sfs_pkg::REG_FRAME_PERIOD)
			period_now = data;
	endtask

	// All three registers; junk above the register width must be masked off.
	task automatic configure(logic [sfs_pkg::FCNT_BITS-1:0] cnt,
		logic [sfs_pkg::FPER_BITS-1:0] per, logic [sfs_pkg::MODE_BITS-1:0] mode);
		write_reg(sfs_pkg::REG_FRAME_COUNT, {7'($urandom), cnt});
		write_reg(sfs_pkg::REG_FRAME_PERIOD, per);
		write_reg(sfs_pkg::REG_PLAY_MODE, {13'($urandom), mode});
	endtask

	// Offer one item. tvalid stays high after the transfer so that back-to-back
	// items go in without a gap; a random idle burst drops it first.
	task automatic send_item(logic op, logic [sfs_pkg::ELAPSED_BITS-1:0] el);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap      = $urandom_range(1, 11);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = el;
		do @(posedge clk); while (!s_tready);
	endtask

	// Sender goes quiet until every expected result has been taken.
	// results_due is updated on the edge, so the read there does not yet see that update.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (4) @(posedge clk);
	endtask

	// Elapsed time scaled to the period so a tick covers at most a few frames;
	// wide periods sometimes get fully random 16-bit times.
	function automatic logic [sfs_pkg::ELAPSED_BITS-1:0] pick_elapsed();
		int per;
		int hi;
		int pick;
		per  = (period_now == '0) ? 1 : int'(period_now);
		pick = $urandom_range(0, 9);
		if (per >= 4096 && pick == 0)
			return sfs_pkg::ELAPSED_BITS'($urandom);
		hi = per * 3 + per / 2;
		if (hi > 65535)
			hi = 65535;
		case (pick)
			1:       return '0;
			2:       return sfs_pkg::ELAPSED_BITS'(per);
			3:       return sfs_pkg::ELAPSED_BITS'(per - 1);
			default: return sfs_pkg::ELAPSED_BITS'($urandom_range(0, hi));
		endcase
	endfunction

	task automatic random_phase(int n_items, bit hold_rx);
		logic [sfs_pkg::FCNT_BITS-1:0] cnt;
		logic [sfs_pkg::FPER_BITS-1:0] per;
		int                            pick;
		bit                            restart;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			cnt = sfs_pkg::FCNT_BITS'($urandom_range(1, 12));
		else if (pick == 6)
			cnt = sfs_pkg::FCNT_BITS'(sfs_pkg::DEF_MAX_FRAMES);
		else if (pick == 7)   // clamps to the maximum
			cnt = sfs_pkg::FCNT_BITS'($urandom_range(sfs_pkg::DEF_MAX_FRAMES + 1, 511));
		else if (pick == 8)
			cnt = '0;                                      // clamps to one frame
		else
			cnt = sfs_pkg::FCNT_BITS'($urandom_range(1, sfs_pkg::DEF_MAX_FRAMES - 1));
		pick = $urandom_range(0, 9);
		if (pick < 5)
			per = sfs_pkg::FPER_BITS'($urandom_range(1, 16));
		else if (pick < 7)
			per = sfs_pkg::FPER_BITS'($urandom_range(17, 4095));
		else if (pick < 9)
			per = sfs_pkg::FPER_BITS'($urandom_range(4096, 65535));
		else
			per = '0;
		restart = ($urandom_range(0, 3) != 0);
		// Without a restart only the count (and maybe the period) moves, so a
		// shrinking count lands on a sequence that is still playing.
		if (restart)
			configure(cnt, per, sfs_pkg::MODE_BITS'($urandom));
		else begin
			write_reg(sfs_pkg::REG_FRAME_COUNT, {7'($urandom), cnt});
			if ($urandom_range(0, 1) == 0)
				write_reg(sfs_pkg::REG_FRAME_PERIOD, per);
		end
		if (hold_rx) begin
			@(posedge clk);
			rx_hold_req = 1'b1;
		end
		if (restart)
			send_item(sfs_pkg::OP_PLAY, sfs_pkg::ELAPSED_BITS'($urandom));
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_item(sfs_pkg::OP_PLAY, sfs_pkg::ELAPSED_BITS'($urandom));
			else
				send_item(sfs_pkg::OP_TICK, pick_elapsed());
		end
		drain();
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request during which
	// the sender keeps offering, so the block backs up and drops s_tready.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_gap      = RX_HOLD_CYCLES;
			end else if (rx_gap == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(1, 11);
			end
			if (rx_gap > 0) begin
				m_tready = 1'b0;
				rx_gap--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: one frame, period 1000, loop
		send_item(sfs_pkg::OP_TICK, 16'hFFFF);   // stopped, tick ignored
		send_item(sfs_pkg::OP_PLAY, 16'hFFFF);
		send_item(sfs_pkg::OP_TICK, 16'd500);    // first tick after play only clears the sum
		send_item(sfs_pkg::OP_TICK, 16'd999);
		send_item(sfs_pkg::OP_TICK, 16'd1);      // loop on a single frame
		drain();

		// zero count and zero period both act as one; stop at the top end
		configure(9'd0, 16'd0, 3'd0);
		send_item(sfs_pkg::OP_PLAY, 16'd0);
		send_item(sfs_pkg::OP_TICK, 16'd0);
		send_item(sfs_pkg::OP_TICK, 16'd1);
		send_item(sfs_pkg::OP_TICK, 16'd5);      // already stopped
		drain();

		// oversized count clamps to the maximum, reverse start from the last frame
		configure(9'h1FF, 16'hFFFF, 3'd7);
		send_item(sfs_pkg::OP_PLAY, 16'hA5A5);
		send_item(sfs_pkg::OP_TICK, 16'hFFFF);
		send_item(sfs_pkg::OP_TICK, 16'hFFFF);
		send_item(sfs_pkg::OP_TICK, 16'hFFFF);
		drain();

		// bounce at the bottom, stop at the top with a remainder left in the sum
		configure(9'd3, 16'd2, 3'd3);
		send_item(sfs_pkg::OP_PLAY, 16'd0);
		send_item(sfs_pkg::OP_TICK, 16'd0);
		send_item(sfs_pkg::OP_TICK, 16'd7);
		send_item(sfs_pkg::OP_TICK, 16'd4);
		drain();

		// count lowered while playing: next step folds back into range
		configure(9'd8, 16'd1, 3'd4);
		send_item(sfs_pkg::OP_PLAY, 16'd0);
		send_item(sfs_pkg::OP_TICK, 16'd0);
		send_item(sfs_pkg::OP_TICK, 16'd6);
		drain();
		write_reg(sfs_pkg::REG_FRAME_COUNT, 16'd3);
		write_reg(REG_SPARE, 16'hFFFF);
		send_item(sfs_pkg::OP_TICK, 16'd1);
		send_item(sfs_pkg::OP_TICK, 16'd2);
		send_item(sfs_pkg::OP_PLAY, 16'd0);      // restart while running
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p >= RAND_PHASES - CALM_PHASES)
				idle_on = 1'b0;
			random_phase(ITEMS_PER_PHASE, p == HOLD_PHASE);
		end

		drain();
		repeat (20) @(posedge clk);
		if (chk_errors == 0 && results_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#(200_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
